/* rtl/core/adcdc_pkg.sv */
`timescale 1ns / 1ps

package adcdc_pkg;

   typedef logic [11:0]        field12_type;
   typedef logic signed [15:0] pcm_type;
   typedef logic [7:0]         csr_index_type;
   typedef logic [15:0]        csr_data_type;

   // Configuration register indexes.
   localparam csr_index_type CSR_GAIN_SHIFT     = 8'd0;
   localparam csr_index_type CSR_DC_TRACK_SHIFT = 8'd1;

   localparam logic [3:0] GAIN_SHIFT_RESET     = 4'd4;
   localparam logic [3:0] DC_TRACK_SHIFT_RESET = 4'd10;

   // DC estimate is Q12.8, reset to mid-scale.
   localparam int         DC_W        = 20;
   localparam logic [19:0] DC_RESET_Q8 = 20'd2048 << 8;

   localparam int FIELD_W = 12;

   localparam pcm_type PCM_MAX = 16'sh7FFF;
   localparam pcm_type PCM_MIN = -16'sh8000;

endpackage

/* rtl/core/adc_audio_dc_removal_pcm.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// req      in         req_valid / req_ready  req_raw_sample
// rsp      out        rsp_valid / rsp_ready  rsp_pcm_sample, rsp_block_last, rsp_block_*
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata (always ready)
//
// One word per cycle unless rsp stalls; each word passes the mid, then the rsp register.
// The first stage runs the DC tracker, smoothing, gain and block statistics; the second
// turns the block's absolute sum into a mean, by a shift when the block length is a power
// of two and else by one constant-reciprocal multiply.
// Reset is synchronous and restores the registers, the DC estimate and the block counters.
// A stall on rsp holds both stages; req_ready drops only when both stages are full.
module adc_audio_dc_removal_pcm #(
   parameter int BLOCK_SAMPLES = 256,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  adcdc_pkg::field12_type req_raw_sample,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output adcdc_pkg::pcm_type     rsp_pcm_sample,
   output logic                   rsp_block_last,
   output adcdc_pkg::field12_type rsp_block_raw_min,
   output adcdc_pkg::field12_type rsp_block_raw_max,
   output adcdc_pkg::field12_type rsp_block_peak_abs,
   output adcdc_pkg::field12_type rsp_block_avg_abs,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  adcdc_pkg::csr_index_type csr_index,
   input  adcdc_pkg::csr_data_type  csr_wdata
);
   import adcdc_pkg::*;

   localparam int RAW_USED = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam logic [FIELD_W-1:0] RAW_MASK = FIELD_W'((64'd1 << RAW_USED) - 64'd1);
   localparam int IDX_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_SAMPLES - 1);
   // Absolute values are at most 4095, so this holds a whole block's sum.
   localparam int SUM_W = FIELD_W + IDX_W;
   localparam bit BLOCK_POW2 = (BLOCK_SAMPLES & (BLOCK_SAMPLES - 1)) == 0;

   // Configuration.
   logic [3:0] gain_ff, gain_in;
   logic [3:0] track_ff, track_in;

   // Filter and block state.
   logic [DC_W-1:0]        dc_ff, dc_in;
   logic signed [12:0]     prev_ff, prev_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [FIELD_W-1:0]     min_ff, min_in;
   logic [FIELD_W-1:0]     max_ff, max_in;
   logic [FIELD_W-1:0]     peak_ff, peak_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   // Middle stage.
   logic                   mid_valid_ff, mid_valid_in;
   pcm_type                mid_pcm_ff, mid_pcm_in;
   logic                   mid_last_ff, mid_last_in;
   logic [FIELD_W-1:0]     mid_min_ff, mid_min_in;
   logic [FIELD_W-1:0]     mid_max_ff, mid_max_in;
   logic [FIELD_W-1:0]     mid_peak_ff, mid_peak_in;
   logic [SUM_W-1:0]       mid_sum_ff, mid_sum_in;

   // Output stage.
   logic                   rsp_valid_ff, rsp_valid_in;
   pcm_type                rsp_pcm_ff, rsp_pcm_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [FIELD_W-1:0]     rsp_min_ff, rsp_min_in;
   logic [FIELD_W-1:0]     rsp_max_ff, rsp_max_in;
   logic [FIELD_W-1:0]     rsp_peak_ff, rsp_peak_in;
   logic [FIELD_W-1:0]     rsp_avg_ff, rsp_avg_in;

   logic                   req_fire;
   logic                   move_out;
   logic                   blk_end;

   logic [FIELD_W-1:0]     raw;
   logic signed [20:0]     dc_diff;
   logic signed [20:0]     dc_step;
   logic signed [20:0]     dc_sum;
   logic signed [12:0]     centered;
   logic signed [13:0]     pair_sum;
   logic signed [13:0]     halved;
   logic signed [12:0]     filtered;
   logic [FIELD_W-1:0]     absf;
   logic signed [27:0]     scaled;
   logic [FIELD_W-1:0]     min_sel;
   logic [FIELD_W-1:0]     max_sel;
   logic [FIELD_W-1:0]     peak_sel;
   logic [SUM_W-1:0]       sum_sel;
   logic [FIELD_W-1:0]     avg_val;

   assign csr_ready = 1'b1;

   assign move_out  = mid_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !mid_valid_ff || move_out;
   assign req_fire  = req_valid && req_ready;
   assign blk_end   = (idx_ff == IDX_LAST);

   always_comb begin
      gain_in  = gain_ff;
      track_in = track_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_SHIFT:     gain_in  = csr_wdata[3:0];
            CSR_DC_TRACK_SHIFT: track_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // DC tracker, smoothing and gain.
   always_comb begin
      raw      = req_raw_sample & RAW_MASK;
      dc_diff  = $signed({1'b0, raw, 8'h00}) - $signed({1'b0, dc_ff});
      dc_step  = dc_diff >>> track_ff;
      dc_sum   = $signed({1'b0, dc_ff}) + dc_step;
      centered = $signed({1'b0, raw}) - $signed({1'b0, dc_sum[19:8]});
      pair_sum = {centered[12], centered} + {prev_ff[12], prev_ff};
      // Halving rounds toward zero, so negative sums get one added first.
      halved   = (pair_sum + {13'd0, pair_sum[13]}) >>> 1;
      filtered = halved[12:0];
      absf     = filtered[12] ? FIELD_W'(-filtered) : FIELD_W'(filtered);
      scaled   = {{15{filtered[12]}}, filtered} <<< gain_ff;
      if (scaled > 28'(PCM_MAX)) begin
         mid_pcm_in = PCM_MAX;
      end else if (scaled < 28'(PCM_MIN)) begin
         mid_pcm_in = PCM_MIN;
      end else begin
         mid_pcm_in = scaled[15:0];
      end
   end

   // Block statistics including the current word.
   always_comb begin
      min_sel  = (raw < min_ff) ? raw : min_ff;
      max_sel  = (raw > max_ff) ? raw : max_ff;
      peak_sel = (absf > peak_ff) ? absf : peak_ff;
      sum_sel  = sum_ff + SUM_W'(absf);

      dc_in   = dc_ff;
      prev_in = prev_ff;
      idx_in  = idx_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      peak_in = peak_ff;
      sum_in  = sum_ff;
      if (req_fire) begin
         dc_in   = dc_sum[19:0];
         prev_in = centered;
         if (blk_end) begin
            idx_in  = '0;
            min_in  = '1;
            max_in  = '0;
            peak_in = '0;
            sum_in  = '0;
         end else begin
            idx_in  = idx_ff + 1'b1;
            min_in  = min_sel;
            max_in  = max_sel;
            peak_in = peak_sel;
            sum_in  = sum_sel;
         end
      end

      mid_last_in  = blk_end;
      mid_min_in   = min_sel;
      mid_max_in   = max_sel;
      mid_peak_in  = peak_sel;
      mid_sum_in   = sum_sel;
      mid_valid_in = req_fire || (mid_valid_ff && !move_out);
   end

   // Mean of the block: a shift for power-of-two blocks, else an exact reciprocal multiply.
   generate
      if (BLOCK_POW2) begin : g_avg_shift
         logic [SUM_W-1:0] avg_shift;
         assign avg_shift = mid_sum_ff >> IDX_W;
         assign avg_val   = avg_shift[FIELD_W-1:0];
      end else begin : g_avg_recip
         localparam int RECIP_SHIFT = SUM_W + IDX_W;
         localparam logic [63:0] RECIP_FULL =
            ((64'd1 << RECIP_SHIFT) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES);
         localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
         logic [2*SUM_W:0] avg_prod;
         assign avg_prod = (2*SUM_W+1)'(mid_sum_ff) * (2*SUM_W+1)'(RECIP);
         assign avg_val  = avg_prod[RECIP_SHIFT +: FIELD_W];
      end
   endgenerate

   always_comb begin
      rsp_pcm_in  = rsp_pcm_ff;
      rsp_last_in = rsp_last_ff;
      rsp_min_in  = rsp_min_ff;
      rsp_max_in  = rsp_max_ff;
      rsp_peak_in = rsp_peak_ff;
      rsp_avg_in  = rsp_avg_ff;
      if (move_out) begin
         rsp_pcm_in  = mid_pcm_ff;
         rsp_last_in = mid_last_ff;
         rsp_min_in  = mid_last_ff ? mid_min_ff  : '0;
         rsp_max_in  = mid_last_ff ? mid_max_ff  : '0;
         rsp_peak_in = mid_last_ff ? mid_peak_ff : '0;
         rsp_avg_in  = mid_last_ff ? avg_val     : '0;
      end
      rsp_valid_in = move_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_SHIFT_RESET;
         track_ff     <= DC_TRACK_SHIFT_RESET;
         dc_ff        <= DC_RESET_Q8;
         prev_ff      <= '0;
         idx_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         peak_ff      <= '0;
         sum_ff       <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         track_ff     <= track_in;
         dc_ff        <= dc_in;
         prev_ff      <= prev_in;
         idx_ff       <= idx_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mid_pcm_ff  <= mid_pcm_in;
         mid_last_ff <= mid_last_in;
         mid_min_ff  <= mid_min_in;
         mid_max_ff  <= mid_max_in;
         mid_peak_ff <= mid_peak_in;
         mid_sum_ff  <= mid_sum_in;
      end
      rsp_pcm_ff  <= rsp_pcm_in;
      rsp_last_ff <= rsp_last_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pcm_sample     = rsp_pcm_ff;
   assign rsp_block_last     = rsp_last_ff;
   assign rsp_block_raw_min  = rsp_min_ff;
   assign rsp_block_raw_max  = rsp_max_ff;
   assign rsp_block_peak_abs = rsp_peak_ff;
   assign rsp_block_avg_abs  = rsp_avg_ff;

   a_stats_zero_midblock: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_block_last) |->
         (rsp_block_raw_min == '0 && rsp_block_raw_max == '0 &&
          rsp_block_peak_abs == '0 && rsp_block_avg_abs == '0))
      else $error("block statistics nonzero on a word that does not close a block");

   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_last) |-> (rsp_block_raw_min <= rsp_block_raw_max))
      else $error("block raw minimum above raw maximum");

   a_mean_below_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_last) |-> (rsp_block_avg_abs <= rsp_block_peak_abs))
      else $error("block mean absolute value above block peak");

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && blk_end) |=> (idx_ff == '0 && sum_ff == '0 && peak_ff == '0))
      else $error("block counters not cleared after the closing word");

endmodule
